// ===== rtl/core/bfsa_pkg.sv =====
`timescale 1ns / 1ps

package bfsa_pkg;

   // fixed field widths
   localparam int unsigned NUM_W  = 14;
   localparam int unsigned REQ_W  = 5;
   localparam int unsigned WORD_W = 32;

   // parameter defaults
   localparam int unsigned MAP_BITS_DEF    = 8192;
   localparam int unsigned MAX_REQUEST_DEF = 16;

   // register reset values
   localparam logic [NUM_W-1:0] INODE_COUNT_RST = 14'd32;
   localparam logic [NUM_W-1:0] BLOCK_COUNT_RST = 14'd128;
   localparam logic [NUM_W-1:0] RESERVED_RST    = 14'd11;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      OP_MARK_USED   = 2'd0,
      OP_MARK_FREE   = 2'd1,
      OP_FIND_INODE  = 2'd2,
      OP_FIND_BLOCKS = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_INODE_COUNT = 2'd0,
      CSR_BLOCK_COUNT = 2'd1,
      CSR_RESERVED    = 2'd2
   } csr_index_type;

   // map select codes
   localparam logic SEL_INODE = 1'b0;
   localparam logic SEL_BLOCK = 1'b1;

   // index of the lowest set bit of a word (zero when none set)
   function automatic logic [4:0] first_set(input word_type w);
      logic [4:0] idx;
      idx = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) idx = 5'(i);
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/bitmap_free_space_allocator_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  op, map_select, object_number, request_count
// rsp      out        rsp_valid/rsp_ready  found_number, status, last
// csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Mark ops pass through S_MARK_RD and S_MARK_WR before S_RESP presents their rsp word;
// out-of-range requests reach S_RESP in the cycle after the req word is taken. Each rsp
// word is held until rsp_ready takes it. Searches read one 32-bit map word per cycle,
// while no free bit of the current word is being taken, through one read port and one
// lowest-free-bit unit; each response word then passes S_EMIT_RD, S_EMIT_LD and S_RESP.
// After reset a clearing pass writes MAP_BITS/32 words of both maps before req_ready
// rises; csr writes are taken at any time.
// A stalled rsp holds the block; no new req word is taken until the last one goes.

module bitmap_free_space_allocator_top #(
   parameter int unsigned MAP_BITS    = bfsa_pkg::MAP_BITS_DEF,
   parameter int unsigned MAX_REQUEST = bfsa_pkg::MAX_REQUEST_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_op,
   input  logic                      req_map_select,
   input  logic [bfsa_pkg::NUM_W-1:0] req_object_number,
   input  logic [bfsa_pkg::REQ_W-1:0] req_request_count,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [bfsa_pkg::NUM_W-1:0] rsp_found_number,
   output logic [1:0]                rsp_status,
   output logic                      rsp_last,
   // register write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [bfsa_pkg::NUM_W-1:0] csr_wdata
);

   localparam int unsigned NW        = bfsa_pkg::NUM_W;
   localparam int unsigned MAP_WORDS = (MAP_BITS + 31) / 32;
   localparam int unsigned AW        = $clog2(MAP_WORDS);
   localparam int unsigned CW        = $clog2(MAX_REQUEST + 1);
   localparam int unsigned FW        = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_MARK_RD = 8'b0000_0100,
      S_MARK_WR = 8'b0000_1000,
      S_SCAN    = 8'b0001_0000,
      S_EMIT_RD = 8'b0010_0000,
      S_EMIT_LD = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [AW-1:0]     clear_addr_ff, clear_addr_in;
   logic              pend_ff, pend_in;
   logic              fetch_more_ff, fetch_more_in;

   // configuration
   logic [NW-1:0]     inode_count_ff, block_count_ff, reserved_ff;

   // operation context
   logic              sel_ff, sel_in;
   logic              mark_used_ff, mark_used_in;
   logic [NW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     start_word_ff, start_word_in;
   logic [4:0]        start_bit_ff, start_bit_in;
   logic [AW-1:0]     last_word_ff, last_word_in;
   logic [4:0]        end_bit_ff, end_bit_in;
   logic [AW-1:0]     fetch_addr_ff, fetch_addr_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [AW-1:0]     free_word_ff, free_word_in;
   bfsa_pkg::word_type free_ff, free_in;
   logic [CW-1:0]     need_ff, need_in;
   logic [CW-1:0]     got_ff, got_in;
   logic [CW-1:0]     emit_idx_ff, emit_idx_in;

   // response word
   logic [NW-1:0]     rsp_num_ff, rsp_num_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   // map memories
   bfsa_pkg::word_type ino_map_ff [MAP_WORDS];
   bfsa_pkg::word_type blk_map_ff [MAP_WORDS];
   bfsa_pkg::word_type ino_rd_ff, blk_rd_ff;
   logic              ino_we, blk_we, map_re;
   logic [AW-1:0]     map_waddr, map_raddr;
   bfsa_pkg::word_type map_wdata, rd_word;

   // found-number buffer
   logic [NW-1:0]     found_ff [MAX_REQUEST];
   logic [NW-1:0]     found_rd_ff;
   logic              found_we, found_re;
   logic [NW-1:0]     found_wdata;

   // scan unit signals
   logic [NW-1:0]     limit_ino, limit_blk, limit_sel;
   logic [NW-1:0]     scan_start, scan_limit, scan_lim_m1;
   logic [4:0]        lo_bit, hi_bit, pick_bit;
   bfsa_pkg::word_type range_mask, pick_mask;
   logic              consume, issue;

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_found_number = rsp_num_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;
   assign csr_ready        = 1'b1;

   // clamp counts to the map size
   assign limit_ino = (32'(inode_count_ff) > 32'(MAP_BITS)) ? NW'(MAP_BITS) : inode_count_ff;
   assign limit_blk = (32'(block_count_ff) > 32'(MAP_BITS)) ? NW'(MAP_BITS) : block_count_ff;
   assign limit_sel = req_map_select ? limit_blk : limit_ino;

   // scan window for a new search
   assign scan_start  = (req_op == bfsa_pkg::OP_FIND_INODE) ? reserved_ff : '0;
   assign scan_limit  = (req_op == bfsa_pkg::OP_FIND_INODE) ? limit_ino : limit_blk;
   assign scan_lim_m1 = scan_limit - NW'(1);

   // valid-range mask for the pending word
   assign lo_bit     = (pend_addr_ff == start_word_ff) ? start_bit_ff : 5'd0;
   assign hi_bit     = (pend_addr_ff == last_word_ff) ? end_bit_ff : 5'd31;
   assign range_mask = ({bfsa_pkg::WORD_W{1'b1}} << lo_bit)
                     & ({bfsa_pkg::WORD_W{1'b1}} >> (5'd31 - hi_bit));
   assign rd_word    = sel_ff ? blk_rd_ff : ino_rd_ff;

   // lowest free bit of the current word
   assign pick_bit  = bfsa_pkg::first_set(free_ff);
   assign pick_mask = bfsa_pkg::word_type'(1) << pick_bit;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      pend_in       = pend_ff;
      fetch_more_in = fetch_more_ff;
      sel_in        = sel_ff;
      mark_used_in  = mark_used_ff;
      pos_in        = pos_ff;
      start_word_in = start_word_ff;
      start_bit_in  = start_bit_ff;
      last_word_in  = last_word_ff;
      end_bit_in    = end_bit_ff;
      fetch_addr_in = fetch_addr_ff;
      pend_addr_in  = pend_addr_ff;
      free_word_in  = free_word_ff;
      free_in       = free_ff;
      need_in       = need_ff;
      got_in        = got_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_num_in    = rsp_num_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ino_we        = 1'b0;
      blk_we        = 1'b0;
      map_re        = 1'b0;
      map_waddr     = clear_addr_ff;
      map_raddr     = fetch_addr_ff;
      map_wdata     = '0;
      found_we      = 1'b0;
      found_re      = 1'b0;
      found_wdata   = NW'({free_word_ff, pick_bit}) + NW'(1);
      consume       = 1'b0;
      issue         = 1'b0;

      case (state_ff)
         // zero both maps one word a cycle
         S_CLEAR: begin
            ino_we        = 1'b1;
            blk_we        = 1'b1;
            clear_addr_in = clear_addr_ff + AW'(1);
            if (clear_addr_ff == AW'(MAP_WORDS - 1)) state_in = S_IDLE;
         end

         // decode a request word
         S_IDLE: begin
            if (req_valid) begin
               rsp_last_in   = 1'b1;
               rsp_num_in    = '0;
               rsp_status_in = bfsa_pkg::ST_NO_SPACE;
               sel_in        = (req_op == bfsa_pkg::OP_FIND_BLOCKS) ? bfsa_pkg::SEL_BLOCK
                             : (req_op == bfsa_pkg::OP_FIND_INODE) ? bfsa_pkg::SEL_INODE
                             : req_map_select;
               mark_used_in  = (req_op == bfsa_pkg::OP_MARK_USED);
               pos_in        = req_object_number - NW'(1);
               start_word_in = AW'(scan_start >> 5);
               start_bit_in  = scan_start[4:0];
               last_word_in  = AW'(scan_lim_m1 >> 5);
               end_bit_in    = scan_lim_m1[4:0];
               fetch_addr_in = AW'(scan_start >> 5);
               fetch_more_in = 1'b1;
               pend_in       = 1'b0;
               free_in       = '0;
               got_in        = '0;
               need_in       = (req_op == bfsa_pkg::OP_FIND_INODE) ? CW'(1)
                                                                   : CW'(req_request_count);
               case (req_op)
                  bfsa_pkg::OP_MARK_USED, bfsa_pkg::OP_MARK_FREE: begin
                     rsp_num_in = req_object_number;
                     if (req_object_number == '0 || req_object_number > limit_sel) begin
                        rsp_status_in = bfsa_pkg::ST_BAD_INDEX;
                        state_in      = S_RESP;
                     end else begin
                        rsp_status_in = bfsa_pkg::ST_OK;
                        state_in      = S_MARK_RD;
                     end
                  end
                  bfsa_pkg::OP_FIND_INODE: begin
                     state_in = (scan_start >= scan_limit) ? S_RESP : S_SCAN;
                  end
                  default: begin
                     if (req_request_count == '0) begin
                        state_in = S_RESP;
                     end else if (32'(req_request_count) > MAX_REQUEST) begin
                        rsp_status_in = bfsa_pkg::ST_BAD_INDEX;
                        state_in      = S_RESP;
                     end else begin
                        state_in = (scan_limit == '0) ? S_RESP : S_SCAN;
                     end
                  end
               endcase
            end
         end

         // fetch the word holding the marked bit
         S_MARK_RD: begin
            map_re    = 1'b1;
            map_raddr = AW'(pos_ff >> 5);
            state_in  = S_MARK_WR;
         end

         // set or clear the bit and write the word back
         S_MARK_WR: begin
            map_waddr = AW'(pos_ff >> 5);
            map_wdata = mark_used_ff
                      ? (rd_word | (bfsa_pkg::word_type'(1) << pos_ff[4:0]))
                      : (rd_word & ~(bfsa_pkg::word_type'(1) << pos_ff[4:0]));
            ino_we    = (sel_ff == bfsa_pkg::SEL_INODE);
            blk_we    = (sel_ff == bfsa_pkg::SEL_BLOCK);
            state_in  = S_RESP;
         end

         // take free bits of the current word, refill from the pending read
         S_SCAN: begin
            if (free_ff != '0) begin
               found_we = 1'b1;
               free_in  = free_ff & ~pick_mask;
               got_in   = got_ff + CW'(1);
               if (got_ff + CW'(1) == need_ff) begin
                  emit_idx_in = '0;
                  state_in    = S_EMIT_RD;
               end
            end else if (pend_ff) begin
               consume      = 1'b1;
               free_in      = ~rd_word & range_mask;
               free_word_in = pend_addr_ff;
            end else if (!fetch_more_ff) begin
               rsp_num_in    = '0;
               rsp_status_in = bfsa_pkg::ST_NO_SPACE;
               rsp_last_in   = 1'b1;
               state_in      = S_RESP;
            end
            // keep one read in flight
            issue = fetch_more_ff && (!pend_ff || consume);
            if (issue) begin
               map_re        = 1'b1;
               pend_in       = 1'b1;
               pend_addr_in  = fetch_addr_ff;
               fetch_addr_in = fetch_addr_ff + AW'(1);
               fetch_more_in = (fetch_addr_ff != last_word_ff);
            end else if (consume) begin
               pend_in = 1'b0;
            end
         end

         // read the next found number
         S_EMIT_RD: begin
            found_re = 1'b1;
            state_in = S_EMIT_LD;
         end

         // load the response word
         S_EMIT_LD: begin
            rsp_num_in    = found_rd_ff;
            rsp_status_in = bfsa_pkg::ST_OK;
            rsp_last_in   = (emit_idx_ff + CW'(1) == got_ff);
            state_in      = S_RESP;
         end

         // hold the response until taken
         S_RESP: begin
            if (rsp_ready) begin
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + CW'(1);
                  state_in    = S_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clear_addr_ff  <= '0;
         pend_ff        <= 1'b0;
         fetch_more_ff  <= 1'b0;
         inode_count_ff <= bfsa_pkg::INODE_COUNT_RST;
         block_count_ff <= bfsa_pkg::BLOCK_COUNT_RST;
         reserved_ff    <= bfsa_pkg::RESERVED_RST;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         pend_ff       <= pend_in;
         fetch_more_ff <= fetch_more_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bfsa_pkg::CSR_INODE_COUNT: inode_count_ff <= csr_wdata;
               bfsa_pkg::CSR_BLOCK_COUNT: block_count_ff <= csr_wdata;
               bfsa_pkg::CSR_RESERVED:    reserved_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // operation context and response payload
   always_ff @(posedge clock) begin
      sel_ff        <= sel_in;
      mark_used_ff  <= mark_used_in;
      pos_ff        <= pos_in;
      start_word_ff <= start_word_in;
      start_bit_ff  <= start_bit_in;
      last_word_ff  <= last_word_in;
      end_bit_ff    <= end_bit_in;
      fetch_addr_ff <= fetch_addr_in;
      pend_addr_ff  <= pend_addr_in;
      free_word_ff  <= free_word_in;
      free_ff       <= free_in;
      need_ff       <= need_in;
      got_ff        <= got_in;
      emit_idx_ff   <= emit_idx_in;
      rsp_num_ff    <= rsp_num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // inode map
   always_ff @(posedge clock) begin
      if (ino_we) ino_map_ff[map_waddr] <= map_wdata;
      if (map_re) ino_rd_ff <= ino_map_ff[map_raddr];
   end

   // block map
   always_ff @(posedge clock) begin
      if (blk_we) blk_map_ff[map_waddr] <= map_wdata;
      if (map_re) blk_rd_ff <= blk_map_ff[map_raddr];
   end

   // found-number buffer
   always_ff @(posedge clock) begin
      if (found_we) found_ff[got_ff[FW-1:0]] <= found_wdata;
      if (found_re) found_rd_ff <= found_ff[emit_idx_ff[FW-1:0]];
   end

`ifndef SYNTHESIS
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_got_below_need: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (got_ff < need_ff))
      else $error("scan found more blocks than requested");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bfsa_pkg::ST_OK) |-> (rsp_found_number != '0))
      else $error("ok response carries number zero");

   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!req_ready && !rsp_valid))
      else $error("channel active during map clearing");
`endif

endmodule

// ===== dv/tb_bitmap_free_space_allocator_top.sv =====
`timescale 1ns / 1ps

module tb_bitmap_free_space_allocator_top;
   import bfsa_pkg::*;

   localparam int unsigned MAP_BITS = MAP_BITS_DEF;
   localparam int unsigned MAX_REQ  = MAX_REQUEST_DEF;

   typedef struct {
      logic [NUM_W-1:0] found;
      status_type       status;
      logic             last;
   } alloc_result_type;

   // Mirror of both usage maps and the three registers; queues the result words
   // that each accepted request must produce.
   class alloc_scoreboard_type;
      bit               inode_map [MAP_BITS];
      bit               block_map [MAP_BITS];
      logic [NUM_W-1:0] inode_cnt;
      logic [NUM_W-1:0] block_cnt;
      logic [NUM_W-1:0] reserved_cnt;
      alloc_result_type expected_q[$];
      int               fail_count;

      function new();
         inode_cnt    = INODE_COUNT_RST;
         block_cnt    = BLOCK_COUNT_RST;
         reserved_cnt = RESERVED_RST;
         fail_count   = 0;
      endfunction

      function int unsigned span(logic [NUM_W-1:0] n);
         return (n > MAP_BITS) ? MAP_BITS : int'(n);
      endfunction

      function void set_register(csr_index_type idx, logic [NUM_W-1:0] val);
         case (idx)
            CSR_INODE_COUNT: inode_cnt = val;
            CSR_BLOCK_COUNT: block_cnt = val;
            CSR_RESERVED:    reserved_cnt = val;
            default: ;
         endcase
      endfunction

      function void add_result(logic [NUM_W-1:0] found, status_type st, logic last);
         alloc_result_type r;
         r.found  = found;
         r.status = st;
         r.last   = last;
         expected_q.push_back(r);
      endfunction

      // Apply one accepted request word and queue the result words it causes
      function void note_request(op_type op, logic sel, logic [NUM_W-1:0] num,
                                 logic [REQ_W-1:0] cnt);
         int unsigned      lim;
         bit               hit;
         logic [NUM_W-1:0] run_q[$];
         hit = 1'b0;
         if (op == OP_MARK_USED || op == OP_MARK_FREE) begin
            lim = span(sel == SEL_BLOCK ? block_cnt : inode_cnt);
            if (num == 0 || num > lim) begin
               add_result(num, ST_BAD_INDEX, 1'b1);
            end else begin
               if (sel == SEL_BLOCK) block_map[num - 1] = (op == OP_MARK_USED);
               else inode_map[num - 1] = (op == OP_MARK_USED);
               add_result(num, ST_OK, 1'b1);
            end
         end else if (op == OP_FIND_INODE) begin
            lim = span(inode_cnt);
            // skip the reserved range, take the lowest free inode
            for (int unsigned i = 32'(reserved_cnt); i < lim && !hit; i++) begin
               if (!inode_map[i]) begin
                  add_result(NUM_W'(i + 1), ST_OK, 1'b1);
                  hit = 1'b1;
               end
            end
            if (!hit) add_result('0, ST_NO_SPACE, 1'b1);
         end else begin
            lim = span(block_cnt);
            if (cnt == 0) begin
               add_result('0, ST_NO_SPACE, 1'b1);
            end else if (cnt > MAX_REQ) begin
               add_result('0, ST_BAD_INDEX, 1'b1);
            end else begin
               for (int unsigned i = 0; i < lim && run_q.size() < cnt; i++) begin
                  if (!block_map[i]) run_q.push_back(NUM_W'(i + 1));
               end
               // a partial run is dropped in favor of a single no-space word
               if (run_q.size() < cnt) begin
                  add_result('0, ST_NO_SPACE, 1'b1);
               end else begin
                  foreach (run_q[k]) add_result(run_q[k], ST_OK, k == run_q.size() - 1);
               end
            end
         end
      endfunction

      // Compare one accepted result word against the oldest expectation
      function void check_response(logic [NUM_W-1:0] found, logic [1:0] st, logic last);
         alloc_result_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result word: found_number %0d status %0d last %0d",
                   found, st, last);
            fail_count++;
            return;
         end
         e = expected_q.pop_front();
         if (e.found !== found) begin
            $error("found_number: expected %0d actual %0d", e.found, found);
            fail_count++;
         end
         if (e.status !== st) begin
            $error("status: expected %0d actual %0d", e.status, st);
            fail_count++;
         end
         if (e.last !== last) begin
            $error("last: expected %0d actual %0d", e.last, last);
            fail_count++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   op_type           req_op = OP_MARK_USED;
   logic             req_map_select = SEL_INODE;
   logic [NUM_W-1:0] req_object_number = '0;
   logic [REQ_W-1:0] req_request_count = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [NUM_W-1:0] rsp_found_number;
   logic [1:0]       rsp_status;
   logic             rsp_last;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   csr_index_type    csr_index = CSR_INODE_COUNT;
   logic [NUM_W-1:0] csr_wdata = '0;

   alloc_scoreboard_type sb = new();

   int unsigned stall_left = 0;
   int unsigned rsp_stall_pct = 25;
   bit          send_gaps = 1;

   bitmap_free_space_allocator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_map_select    (req_map_select),
      .req_object_number (req_object_number),
      .req_request_count (req_request_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found_number  (rsp_found_number),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left <= idle_len();
      end
   end

   // Check every accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_response(rsp_found_number, rsp_status, rsp_last);
   end

   // Hold one request word until it is taken; valid stays up for the caller
   task automatic send_item(input op_type op, input logic sel, input logic [NUM_W-1:0] num,
                            input logic [REQ_W-1:0] cnt);
      int unsigned gap;
      gap = send_gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_map_select    <= sel;
      req_object_number <= num;
      req_request_count <= cnt;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      sb.note_request(op, sel, num, cnt);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [NUM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.set_register(idx, val);
   endtask

   task automatic configure(input logic [NUM_W-1:0] n_inode, input logic [NUM_W-1:0] n_block,
                            input logic [NUM_W-1:0] n_resv);
      write_reg(CSR_INODE_COUNT, n_inode);
      write_reg(CSR_BLOCK_COUNT, n_block);
      write_reg(CSR_RESERVED, n_resv);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Mostly in-range numbers, some zero, one past the end, or any 14-bit value
   function automatic logic [NUM_W-1:0] pick_number(input int unsigned lim);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (lim == 0 || r < 6) return NUM_W'($urandom_range(0, (1 << NUM_W) - 1));
      if (r < 8) return '0;
      if (r < 11) return NUM_W'(lim + 1);
      return NUM_W'($urandom_range(1, lim));
   endfunction

   task automatic send_random(input bit fill);
      int unsigned      r;
      int unsigned      lim;
      op_type           op;
      logic             sel;
      logic [NUM_W-1:0] num;
      logic [REQ_W-1:0] cnt;
      r = $urandom_range(0, 99);
      if (r < (fill ? 50 : 30)) op = OP_MARK_USED;
      else if (r < 55) op = OP_MARK_FREE;
      else if (r < 75) op = OP_FIND_INODE;
      else op = OP_FIND_BLOCKS;
      sel = 1'($urandom_range(0, 1));
      lim = sb.span(sel == SEL_BLOCK ? sb.block_cnt : sb.inode_cnt);
      num = pick_number(lim);
      if ($urandom_range(0, 99) < 85) cnt = REQ_W'($urandom_range(1, MAX_REQ));
      else cnt = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
      send_item(op, sel, num, cnt);
   endtask

   initial begin
      logic [NUM_W-1:0] ni;
      logic [NUM_W-1:0] nb;
      logic [NUM_W-1:0] nr;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values: 32 inodes, 128 blocks, 11 reserved
      send_item(OP_FIND_INODE, SEL_BLOCK, 14'd0, 5'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd12, 5'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd1, 5'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd0, 5'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd33, 5'd0);
      send_item(OP_MARK_USED, SEL_BLOCK, 14'd128, 5'd0);
      send_item(OP_MARK_USED, SEL_BLOCK, 14'd129, 5'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd17);
      send_item(OP_FIND_BLOCKS, SEL_BLOCK, 14'd0, 5'd16);
      drain();

      // empty maps: nothing in range, nothing to find
      configure(14'd0, 14'd0, 14'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd1, 5'd0);
      send_item(OP_FIND_INODE, SEL_INODE, 14'd0, 5'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd1);
      drain();

      // full-size maps with only the top inode left to hand out
      configure(14'd8192, 14'd8192, 14'd8191);
      send_item(OP_FIND_INODE, SEL_INODE, 14'd0, 5'd0);
      send_item(OP_MARK_USED, SEL_INODE, 14'd8192, 5'd0);
      send_item(OP_FIND_INODE, SEL_INODE, 14'd0, 5'd0);
      send_item(OP_MARK_USED, SEL_BLOCK, 14'd8192, 5'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd16);
      drain();

      // counts past the map size clamp to it; reserved beyond all inodes
      configure(14'd9000, 14'd16383, 14'd16383);
      send_item(OP_MARK_FREE, SEL_BLOCK, 14'd8193, 5'd0);
      send_item(OP_MARK_FREE, SEL_BLOCK, 14'd8192, 5'd0);
      send_item(OP_FIND_INODE, SEL_INODE, 14'd0, 5'd0);
      drain();

      // too few free blocks for the request
      configure(14'd32, 14'd4, 14'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd5);
      send_item(OP_MARK_USED, SEL_BLOCK, 14'd2, 5'd0);
      send_item(OP_FIND_BLOCKS, SEL_INODE, 14'd0, 5'd4);
      drain();

      // random phases; one uses a full-size block map and a large inode map, others small ones that fill up
      for (int p = 0; p < 6; p++) begin
         if (p == 3) begin
            ni = NUM_W'($urandom_range(1024, MAP_BITS));
            nb = NUM_W'(MAP_BITS);
         end else begin
            ni = NUM_W'($urandom_range(1, 40));
            nb = NUM_W'($urandom_range(4, 48));
         end
         if ($urandom_range(0, 9) == 0) nr = ni + NUM_W'(1);
         else nr = NUM_W'($urandom_range(0, ni / 2));
         configure(ni, nb, nr);
         send_gaps     = !(p == 1 || p == 4);
         rsp_stall_pct = (p == 2 || p == 4) ? 0 : $urandom_range(10, 40);
         for (int n = 0; n < 68; n++) send_random(1'(p % 2));
         drain();
      end

      // let any stray word surface, then report
      repeat (20) @(posedge clock);
      if (sb.fail_count == 0) $display("tb_bitmap_free_space_allocator_top OK");
      else $display("tb_bitmap_free_space_allocator_top NOT OK");
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_bitmap_free_space_allocator_top NOT OK");
      $finish;
   end

endmodule
